// File: hdl/xm1k_pkg.sv
// shared types, codes and the crc step of the block sender
package xm1k_pkg;

   localparam int BLOCK_BYTES = 1024;
   localparam int SHORT_BYTES = 128;
   localparam int QUEUE_DEPTH = 2;
   localparam int ADDR_W      = $clog2(BLOCK_BYTES);
   localparam int IDX_W       = 11;

   localparam logic [2:0] CMD_RX    = 3'd0;
   localparam logic [2:0] CMD_TMO   = 3'd1;
   localparam logic [2:0] CMD_PAY   = 3'd2;
   localparam logic [2:0] CMD_END   = 3'd3;
   localparam logic [2:0] CMD_SLOT  = 3'd4;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_SUB = 8'h1A;
   localparam logic [7:0] CH_C   = 8'h43;

   localparam logic [1:0] REG_LONG  = 2'd0;
   localparam logic [1:0] REG_SYNC  = 2'd1;
   localparam logic [1:0] REG_FRAME = 2'd2;
   localparam logic [1:0] REG_END   = 2'd3;

   localparam logic [2:0] ST_BUSY   = 3'd0;
   localparam logic [2:0] ST_OK     = 3'd1;
   localparam logic [2:0] ST_CANCEL = 3'd2;
   localparam logic [2:0] ST_NOSYNC = 3'd3;
   localparam logic [2:0] ST_FRAME  = 3'd4;
   localparam logic [2:0] ST_ENDERR = 3'd5;

   localparam logic [1:0] WC_TWO  = 2'd0;
   localparam logic [1:0] WC_ONE  = 2'd1;
   localparam logic [1:0] WC_HALF = 2'd2;
   localparam logic [1:0] WC_NONE = 2'd3;

   localparam logic [3:0] PH_SYNC      = 4'd0;
   localparam logic [3:0] PH_SYNC_CAN  = 4'd1;
   localparam logic [3:0] PH_LOAD      = 4'd2;
   localparam logic [3:0] PH_SEND      = 4'd3;
   localparam logic [3:0] PH_REPLY     = 4'd4;
   localparam logic [3:0] PH_REPLY_CAN = 4'd5;
   localparam logic [3:0] PH_EOT_SEND  = 4'd6;
   localparam logic [3:0] PH_EOT_WAIT  = 4'd7;
   localparam logic [3:0] PH_CAN_OUT   = 4'd8;
   localparam logic [3:0] PH_ACK_OUT   = 4'd9;
   localparam logic [3:0] PH_FLUSH     = 4'd10;
   localparam logic [3:0] PH_DONE      = 4'd11;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        want_data;
      logic [1:0]  wait_class;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] byte_count;
   } rsp_type;

   // classified item as it travels from front to back
   typedef struct packed {
      logic       is_rx;
      logic       is_tmo;
      logic       is_pay;
      logic       is_end;
      logic       is_slot;
      logic       d_c;
      logic       d_nak;
      logic       d_can;
      logic       d_ack;
      logic [7:0] data;
   } cls_type;

   typedef struct packed {
      logic [3:0] phase;
      logic       q_full;
   } stat_type;

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// File: hdl/xmodem_1k_sender_top.sv
// top level of the block sender: front end, item queue, back end, checks
// Each item (received byte, timeout, payload byte, end of data, transmit slot) gives one
// result item. Items are taken one per clock while the queue has room: the front end
// queues up to two classified items, and the back end retires one per cycle whenever
// the result register is free or being taken, so the sustained rate is one item per
// cycle while results are taken at once. With an empty queue an item passes a queue
// slot and then the result register. Frame bytes come from a 1024-byte buffer read one
// slot ahead, and the crc or checksum is updated one byte per slot.
module xmodem_1k_sender_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xm1k_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xm1k_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import xm1k_pkg::*;

   logic     q_valid, q_pop;
   cls_type  q_item;
   stat_type stat;

   xm1k_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .q_full    (stat.q_full)
   );

   xm1k_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .phase     (stat.phase)
   );

`ifndef SYNTHESIS
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.status != ST_BUSY)
      else $error("done without status");
   a_busy_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == ST_BUSY)
      else $error("status before done");
   a_load_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.want_data |-> !rsp_data.tx_valid)
      else $error("transmit while loading");
   a_full_pop: assert property (@(posedge clock) disable iff (reset)
      stat.q_full && !q_pop |=> stat.q_full)
      else $error("queue drained without a pop");
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      stat.phase <= PH_DONE)
      else $error("illegal phase");
`endif
endmodule

// File: hdl/xm1k_ram.sv
// generic single write port ram with registered read
module xm1k_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/xm1k_front.sv
// front end: accepts items, classifies them and queues them for the back end
module xm1k_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xm1k_pkg::req_type req_data,
   output logic              q_valid,
   output xm1k_pkg::cls_type q_item,
   input  logic              q_pop,
   output logic              q_full
);
   import xm1k_pkg::*;

   cls_type    slot_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cls_type    cls;
   logic       push;

   always_comb begin
      cls.is_rx   = req_data.cmd == CMD_RX;
      cls.is_tmo  = req_data.cmd == CMD_TMO;
      cls.is_pay  = req_data.cmd == CMD_PAY;
      cls.is_end  = req_data.cmd == CMD_END;
      cls.is_slot = req_data.cmd == CMD_SLOT;
      cls.d_c     = req_data.data_byte == CH_C;
      cls.d_nak   = req_data.data_byte == CH_NAK;
      cls.d_can   = req_data.data_byte == CH_CAN;
      cls.d_ack   = req_data.data_byte == CH_ACK;
      cls.data    = req_data.data_byte;
   end

   assign req_ready = cnt_ff != 2'(QUEUE_DEPTH);
   assign q_full    = !req_ready;
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = q_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= cls;
      end
   end
endmodule

// File: hdl/xm1k_back.sv
// back end: protocol state machine, block buffer and result register
module xm1k_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  xm1k_pkg::cls_type q_item,
   output logic              q_pop,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xm1k_pkg::rsp_type rsp_data,
   output logic [3:0]        phase
);
   import xm1k_pkg::*;

   logic        long_ff;
   logic [7:0]  sync_lim_ff, frame_lim_ff, end_lim_ff;

   logic [IDX_W-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic [7:0]  pkt_ff, pkt_in, att_ff, att_in;
   logic        crc_ff, crc_in;
   logic [15:0] chk_ff, chk_in;
   logic [3:0]  ph_ff, ph_in;
   logic [31:0] len_ff, len_in;
   logic [2:0]  fst_ff, fst_in;
   logic [1:0]  canl_ff, canl_in;

   logic        out_v_ff;
   rsp_type     out_ff, out_in;

   logic        go, txv;
   logic [7:0]  txb, fb, rd_byte;
   logic [IDX_W:0]   size, ip;
   logic [IDX_W-1:0] p;
   logic [IDX_W-1:0] ra_full;
   logic [32:0] len_sum;
   logic        ram_we;
   logic [1:0]  wc;

   assign go    = q_valid && (!out_v_ff || rsp_ready);
   assign q_pop = go;
   assign size  = long_ff ? 12'(BLOCK_BYTES) : 12'(SHORT_BYTES);
   assign ip    = {1'b0, idx_ff};
   assign p     = idx_ff - 11'd3;
   assign ram_we = go && ph_ff == PH_LOAD && q_item.is_pay;
   // read ahead for the index the next slot will use
   assign ra_full = idx_in - 11'd3;
   assign len_sum = {1'b0, len_ff} + {21'd0, size};

   xm1k_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[ADDR_W-1:0]),
      .wdata (q_item.data),
      .raddr (ra_full[ADDR_W-1:0]),
      .rdata (rd_byte)
   );

   always_comb begin
      fill_in = fill_ff; idx_in = idx_ff; pkt_in = pkt_ff; att_in = att_ff;
      crc_in = crc_ff; chk_in = chk_ff; ph_in = ph_ff; len_in = len_ff;
      fst_in = fst_ff; canl_in = canl_ff;
      txv = 1'b0; txb = 8'h00; fb = 8'h00;
      if (go) begin
         case (ph_ff)
            PH_SYNC: begin
               if (q_item.is_rx && q_item.d_c) begin
                  crc_in = 1'b1; fill_in = '0; ph_in = PH_LOAD;
               end else if (q_item.is_rx && q_item.d_nak) begin
                  crc_in = 1'b0; fill_in = '0; ph_in = PH_LOAD;
               end else if (q_item.is_rx && q_item.d_can) begin
                  ph_in = PH_SYNC_CAN;
               end else if (q_item.is_rx || q_item.is_tmo) begin
                  att_in = att_ff + 8'd1;
                  if (att_in >= sync_lim_ff) begin
                     fst_in = ST_NOSYNC; canl_in = 2'd3; ph_in = PH_CAN_OUT;
                  end else ph_in = PH_SYNC;
               end
            end
            PH_SYNC_CAN: begin
               if (q_item.is_rx && q_item.d_can) begin
                  fst_in = ST_CANCEL; ph_in = PH_ACK_OUT;
               end else if (q_item.is_rx || q_item.is_tmo) begin
                  att_in = att_ff + 8'd1;
                  if (att_in >= sync_lim_ff) begin
                     fst_in = ST_NOSYNC; canl_in = 2'd3; ph_in = PH_CAN_OUT;
                  end else ph_in = PH_SYNC;
               end
            end
            PH_LOAD: begin
               if (q_item.is_pay) begin
                  fill_in = fill_ff + 11'd1;
                  if ({1'b0, fill_in} >= size) begin
                     ph_in = PH_SEND; idx_in = '0; att_in = 8'd0;
                  end
               end else if (q_item.is_end) begin
                  if (fill_ff != '0) begin
                     ph_in = PH_SEND; idx_in = '0; att_in = 8'd0;
                  end else begin
                     ph_in = PH_EOT_SEND; att_in = 8'd0;
                  end
               end
            end
            PH_SEND: begin
               if (q_item.is_slot) begin
                  txv = 1'b1;
                  idx_in = idx_ff + 11'd1;
                  if (idx_ff == 11'd0) begin
                     fb = long_ff ? CH_STX : CH_SOH;
                     chk_in = 16'd0;
                  end else if (idx_ff == 11'd1) begin
                     fb = pkt_ff;
                  end else if (idx_ff == 11'd2) begin
                     fb = ~pkt_ff;
                  end else if (ip < size + 12'd3) begin
                     if (p < fill_ff) fb = rd_byte;
                     else fb = (p == fill_ff) ? CH_SUB : 8'h00;
                     if (crc_ff) chk_in = crc16_step(chk_ff, fb);
                     else chk_in = {8'h00, chk_ff[7:0] + fb};
                  end else if (ip == size + 12'd3 && crc_ff) begin
                     fb = chk_ff[15:8];
                  end else begin
                     // low check byte closes the frame
                     fb = chk_ff[7:0];
                     att_in = att_ff + 8'd1;
                     ph_in = PH_REPLY;
                  end
                  txb = fb;
               end
            end
            PH_REPLY, PH_REPLY_CAN: begin
               if (q_item.is_rx && q_item.d_ack && ph_ff == PH_REPLY) begin
                  pkt_in = pkt_ff + 8'd1;
                  len_in = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];
                  if ({1'b0, fill_ff} < size) begin
                     ph_in = PH_EOT_SEND; att_in = 8'd0;
                  end else begin
                     fill_in = '0; ph_in = PH_LOAD;
                  end
               end else if (q_item.is_rx && q_item.d_can) begin
                  if (ph_ff == PH_REPLY) ph_in = PH_REPLY_CAN;
                  else begin
                     fst_in = ST_CANCEL; ph_in = PH_ACK_OUT;
                  end
               end else if (q_item.is_rx || q_item.is_tmo) begin
                  if (att_ff >= frame_lim_ff) begin
                     fst_in = ST_FRAME; canl_in = 2'd3; ph_in = PH_CAN_OUT;
                  end else begin
                     ph_in = PH_SEND; idx_in = '0;
                  end
               end
            end
            PH_EOT_SEND: begin
               if (q_item.is_slot) begin
                  txv = 1'b1; txb = CH_EOT;
                  att_in = att_ff + 8'd1;
                  ph_in = PH_EOT_WAIT;
               end
            end
            PH_EOT_WAIT: begin
               if (q_item.is_rx && q_item.d_ack) begin
                  fst_in = ST_OK; ph_in = PH_FLUSH;
               end else if (q_item.is_rx || q_item.is_tmo) begin
                  if (att_ff >= end_lim_ff) begin
                     fst_in = ST_ENDERR; ph_in = PH_FLUSH;
                  end else ph_in = PH_EOT_SEND;
               end
            end
            PH_CAN_OUT: begin
               if (q_item.is_slot) begin
                  txv = 1'b1; txb = CH_CAN;
                  if (canl_ff != 2'd0) canl_in = canl_ff - 2'd1;
                  if (canl_in == 2'd0) ph_in = PH_FLUSH;
               end
            end
            PH_ACK_OUT: begin
               if (q_item.is_slot) begin
                  txv = 1'b1; txb = CH_ACK; ph_in = PH_FLUSH;
               end
            end
            PH_FLUSH: begin
               if (q_item.is_tmo) ph_in = PH_DONE;
            end
            default: ph_in = PH_DONE;
         endcase
      end
   end

   always_comb begin
      case (ph_in)
         PH_SYNC, PH_EOT_WAIT:               wc = WC_TWO;
         PH_SYNC_CAN, PH_REPLY, PH_REPLY_CAN: wc = WC_ONE;
         PH_FLUSH:                           wc = WC_HALF;
         default:                            wc = WC_NONE;
      endcase
      out_in.tx_valid   = txv;
      out_in.tx_byte    = txb;
      out_in.want_data  = ph_in == PH_LOAD;
      out_in.wait_class = wc;
      out_in.done_res   = ph_in == PH_DONE;
      out_in.status     = (ph_in == PH_DONE) ? fst_in : ST_BUSY;
      out_in.byte_count = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff <= 1'b1; sync_lim_ff <= 8'd64; frame_lim_ff <= 8'd25; end_lim_ff <= 8'd10;
         fill_ff <= '0; idx_ff <= '0; pkt_ff <= 8'd1; att_ff <= 8'd0; crc_ff <= 1'b1;
         chk_ff <= 16'd0; ph_ff <= PH_SYNC; len_ff <= 32'd0; fst_ff <= ST_BUSY;
         canl_ff <= 2'd0; out_v_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LONG:  long_ff      <= csr_wdata[0];
               REG_SYNC:  sync_lim_ff  <= csr_wdata;
               REG_FRAME: frame_lim_ff <= csr_wdata;
               REG_END:   end_lim_ff   <= csr_wdata;
               default:   long_ff      <= long_ff;
            endcase
         end
         fill_ff <= fill_in; idx_ff <= idx_in; pkt_ff <= pkt_in; att_ff <= att_in;
         crc_ff <= crc_in; chk_ff <= chk_in; ph_ff <= ph_in; len_ff <= len_in;
         fst_ff <= fst_in; canl_ff <= canl_in;
         if (go) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
      if (go) out_ff <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign phase     = ph_ff;
endmodule

// File: bench/testbench.sv
// self-checking bench for the xmodem block sender: queued stimulus, predictor, result checks
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import xm1k_pkg::*;

   typedef enum logic [3:0] {
      SYNCING, SYNC_CAN, LOADING, SENDING, AWAIT_REPLY, REPLY_CAN,
      EOT_SENDING, EOT_AWAIT, CAN_SENDING, ACK_SENDING, FLUSHING, FINISHED
   } xfer_phase_type;

   localparam logic [7:0] IGN_LOAD  = 8'b1111_0011;
   localparam logic [7:0] IGN_SEND  = 8'b1110_1111;
   localparam logic [7:0] IGN_WAIT  = 8'b1111_1100;
   localparam logic [7:0] IGN_FLUSH = 8'b1111_1101;
   localparam logic [7:0] IGN_ALL   = 8'b1111_1111;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = REG_LONG;
   logic [7:0] csr_wdata = '0;

   xmodem_1k_sender_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // predictor state and configuration
   logic        long_blocks = 1'b1;
   logic [7:0]  sync_limit = 8'd64, frame_limit = 8'd25, end_limit = 8'd10;
   logic [7:0]  block_mem [1024];
   logic [10:0] fill_cnt = '0, tx_index = '0;
   logic [7:0]  pkt_num = 8'd1, tries = '0;
   logic        crc_on = 1'b1;
   logic [15:0] check_acc = '0;
   xfer_phase_type xphase = SYNCING;
   logic [31:0] acked_len = '0;
   logic [2:0]  end_code = ST_BUSY;
   logic [1:0]  can_left = '0;

   rsp_type expected_rsps[$];
   req_type pending_reqs[$];
   int      errors = 0;
   int      rsp_count = 0;
   int      items_queued = 0;

   function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      c = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

   function automatic logic [10:0] cur_size();
      return long_blocks ? 11'(BLOCK_BYTES) : 11'(SHORT_BYTES);
   endfunction

   function automatic void give_up(logic [2:0] code);
      end_code = code;
      can_left = 2'd3;
      xphase = CAN_SENDING;
   endfunction

   function automatic void peer_cancel();
      end_code = ST_CANCEL;
      xphase = ACK_SENDING;
   endfunction

   function automatic void sync_failed();
      tries = tries + 8'd1;
      if (tries >= sync_limit) give_up(ST_NOSYNC);
      else xphase = SYNCING;
   endfunction

   function automatic void frame_failed();
      if (tries >= frame_limit) give_up(ST_FRAME);
      else begin
         xphase = SENDING;
         tx_index = '0;
      end
   endfunction

   function automatic void open_frame();
      xphase = SENDING;
      tx_index = '0;
      tries = '0;
   endfunction

   function automatic void open_eot();
      xphase = EOT_SENDING;
      tries = '0;
   endfunction

   function automatic rsp_type sender_step(req_type it);
      rsp_type r;
      logic [10:0] sz, p;
      logic [7:0]  b;
      logic        fin;
      logic        rx;
      r = '0;
      sz = cur_size();
      rx = (it.cmd == CMD_RX);
      case (xphase)
         SYNCING: begin
            if (rx) begin
               if (it.data_byte == CH_C || it.data_byte == CH_NAK) begin
                  crc_on = (it.data_byte == CH_C);
                  fill_cnt = '0;
                  xphase = LOADING;
               end else if (it.data_byte == CH_CAN) xphase = SYNC_CAN;
               else sync_failed();
            end else if (it.cmd == CMD_TMO) sync_failed();
         end
         SYNC_CAN: begin
            if (rx && it.data_byte == CH_CAN) peer_cancel();
            else if (rx || it.cmd == CMD_TMO) sync_failed();
         end
         LOADING: begin
            if (it.cmd == CMD_PAY) begin
               block_mem[fill_cnt[9:0]] = it.data_byte;
               fill_cnt = fill_cnt + 11'd1;
               if (fill_cnt >= sz) open_frame();
            end else if (it.cmd == CMD_END) begin
               if (fill_cnt > 0) open_frame();
               else open_eot();
            end
         end
         SENDING: begin
            if (it.cmd == CMD_SLOT) begin
               fin = 1'b0;
               if (tx_index == 0) begin
                  b = long_blocks ? CH_STX : CH_SOH;
                  check_acc = '0;
               end else if (tx_index == 1) b = pkt_num;
               else if (tx_index == 2) b = ~pkt_num;
               else if (tx_index < sz + 11'd3) begin
                  p = tx_index - 11'd3;
                  if (p < fill_cnt) b = block_mem[p[9:0]];
                  else b = (p == fill_cnt) ? CH_SUB : 8'h00;
                  if (crc_on) check_acc = crc_byte(check_acc, b);
                  else check_acc = {8'h00, check_acc[7:0] + b};
               end else if (tx_index == sz + 11'd3 && crc_on) b = check_acc[15:8];
               else begin
                  b = check_acc[7:0];
                  fin = 1'b1;
               end
               tx_index = tx_index + 11'd1;
               r.tx_valid = 1'b1;
               r.tx_byte = b;
               if (fin) begin
                  tries = tries + 8'd1;
                  xphase = AWAIT_REPLY;
               end
            end
         end
         AWAIT_REPLY: begin
            if (rx && it.data_byte == CH_ACK) begin
               pkt_num = pkt_num + 8'd1;
               if ({1'b0, acked_len} + 33'(sz) > 33'hFFFF_FFFF) acked_len = '1;
               else acked_len = acked_len + 32'(sz);
               if (fill_cnt < sz) open_eot();
               else begin
                  fill_cnt = '0;
                  xphase = LOADING;
               end
            end else if (rx && it.data_byte == CH_CAN) xphase = REPLY_CAN;
            else if (rx || it.cmd == CMD_TMO) frame_failed();
         end
         REPLY_CAN: begin
            if (rx && it.data_byte == CH_CAN) peer_cancel();
            else if (rx || it.cmd == CMD_TMO) frame_failed();
         end
         EOT_SENDING: begin
            if (it.cmd == CMD_SLOT) begin
               r.tx_valid = 1'b1;
               r.tx_byte = CH_EOT;
               tries = tries + 8'd1;
               xphase = EOT_AWAIT;
            end
         end
         EOT_AWAIT: begin
            if (rx && it.data_byte == CH_ACK) begin
               end_code = ST_OK;
               xphase = FLUSHING;
            end else if (rx || it.cmd == CMD_TMO) begin
               if (tries >= end_limit) begin
                  end_code = ST_ENDERR;
                  xphase = FLUSHING;
               end else xphase = EOT_SENDING;
            end
         end
         CAN_SENDING: begin
            if (it.cmd == CMD_SLOT) begin
               r.tx_valid = 1'b1;
               r.tx_byte = CH_CAN;
               if (can_left > 0) can_left = can_left - 2'd1;
               if (can_left == 0) xphase = FLUSHING;
            end
         end
         ACK_SENDING: begin
            if (it.cmd == CMD_SLOT) begin
               r.tx_valid = 1'b1;
               r.tx_byte = CH_ACK;
               xphase = FLUSHING;
            end
         end
         FLUSHING: if (it.cmd == CMD_TMO) xphase = FINISHED;
         default: xphase = FINISHED;
      endcase
      case (xphase)
         SYNCING, EOT_AWAIT:                r.wait_class = WC_TWO;
         SYNC_CAN, AWAIT_REPLY, REPLY_CAN:  r.wait_class = WC_ONE;
         FLUSHING:                          r.wait_class = WC_HALF;
         default:                           r.wait_class = WC_NONE;
      endcase
      r.want_data = (xphase == LOADING);
      r.done_res = (xphase == FINISHED);
      r.status = (xphase == FINISHED) ? end_code : ST_BUSY;
      r.byte_count = acked_len;
      return r;
   endfunction

   // driver: idle gaps per item, with bursts of back-to-back items
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(sender_step(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap <= ((items_queued / 150) % 3 == 0) ? 0 : $urandom_range(0, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stalls, one long hold-off that backs the block up
   int stall_left = 0;
   always @(posedge clock) begin
      int nxt;
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         nxt = (stall_left > 0) ? stall_left - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result item %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.tx_valid !== want.tx_valid || rsp_data.tx_byte !== want.tx_byte ||
                   rsp_data.want_data !== want.want_data ||
                   rsp_data.wait_class !== want.wait_class ||
                   rsp_data.done_res !== want.done_res || rsp_data.status !== want.status ||
                   rsp_data.byte_count !== want.byte_count) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at result %0d: expected %p got %p",
                              rsp_count, want, rsp_data);
               end
            end
            if (rsp_count == 400) nxt = 300;
            else if ((rsp_count / 120) % 3 == 1) nxt = 0;
            else nxt = $urandom_range(0, 12);
         end
         stall_left <= nxt;
         rsp_ready <= (nxt == 0);
      end
   end

   task automatic push_item(logic [2:0] c, logic [7:0] d);
      req_type it;
      it.cmd = c;
      it.data_byte = d;
      pending_reqs.push_back(it);
      items_queued++;
   endtask

   // real item, sometimes preceded by one the current phase ignores
   task automatic offer(logic [2:0] c, logic [7:0] d, logic [7:0] ign);
      logic [2:0] n;
      if ($urandom_range(0, 7) == 0) begin
         do n = 3'($urandom_range(0, 7)); while (!ign[n]);
         push_item(n, 8'($urandom));
      end
      push_item(c, d);
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_LONG:  long_blocks = val[0];
         REG_SYNC:  sync_limit = val;
         REG_FRAME: frame_limit = val;
         default:   end_limit = val;
      endcase
   endtask

   function automatic logic [7:0] plain_reply();
      logic [7:0] v;
      do v = 8'($urandom); while (v == CH_ACK || v == CH_CAN);
      return v;
   endfunction

   // frame slots, then retries until acknowledged
   task automatic send_until_ack(bit with_crc);
      int slots, sent;
      sent = 0;
      slots = int'(cur_size()) + (with_crc ? 5 : 4);
      forever begin
         for (int i = 0; i < slots; i++) offer(CMD_SLOT, 8'h00, IGN_SEND);
         sent++;
         if (sent < frame_limit && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: offer(CMD_RX, CH_NAK, IGN_WAIT);
               1: offer(CMD_TMO, 8'($urandom), IGN_WAIT);
               2: offer(CMD_RX, plain_reply(), IGN_WAIT);
               default: begin
                  offer(CMD_RX, CH_CAN, IGN_WAIT);
                  if ($urandom_range(0, 1)) offer(CMD_RX, plain_reply(), IGN_WAIT);
                  else offer(CMD_TMO, 8'h00, IGN_WAIT);
               end
            endcase
         end else begin
            offer(CMD_RX, CH_ACK, IGN_WAIT);
            break;
         end
      end
   endtask

   initial begin
      bit with_crc;
      int k;
      wait (!reset);
      write_reg(REG_LONG, 8'd1);
      write_reg(REG_SYNC, 8'd255);
      write_reg(REG_FRAME, 8'd255);
      write_reg(REG_END, 8'd255);
      // ignored items, sync misses and both kinds of aborted cancel before sync
      push_item(CMD_PAY, 8'hFF);
      push_item(CMD_END, 8'h00);
      push_item(CMD_SLOT, 8'h55);
      push_item(3'd5, 8'hAA);
      push_item(3'd6, 8'h01);
      push_item(3'd7, 8'h80);
      push_item(CMD_RX, 8'h00);
      push_item(CMD_RX, 8'hFF);
      push_item(CMD_TMO, 8'h00);
      push_item(CMD_RX, CH_CAN);
      push_item(CMD_RX, 8'h41);
      push_item(CMD_RX, CH_CAN);
      push_item(CMD_TMO, 8'h00);
      with_crc = $urandom_range(0, 1);
      push_item(CMD_RX, with_crc ? CH_C : CH_NAK);
      // long block partly loaded, then cut to short size
      for (int i = 0; i < 200; i++) offer(CMD_PAY, 8'($urandom), IGN_LOAD);
      drain();
      write_reg(REG_LONG, 8'd0);
      write_reg(REG_SYNC, 8'd1);
      offer(CMD_PAY, 8'($urandom), IGN_LOAD);
      send_until_ack(with_crc);
      // short blocks; the long last block below brings the total to about 1800
      while (items_queued < 700) begin
         if ($urandom_range(0, 2) == 0) begin
            drain();
            case ($urandom_range(0, 2))
               0: write_reg(REG_FRAME, 8'd1);
               1: write_reg(REG_FRAME, 8'd255);
               default: write_reg(REG_FRAME, 8'($urandom_range(2, 6)));
            endcase
         end
         for (int i = 0; i < SHORT_BYTES; i++) offer(CMD_PAY, 8'($urandom), IGN_LOAD);
         send_until_ack(with_crc);
      end
      // last block: long size, short fill, sent once, then end of transfer
      drain();
      write_reg(REG_LONG, 8'd1);
      write_reg(REG_FRAME, 8'd1);
      write_reg(REG_END, 8'd4);
      k = $urandom_range(1, 40);
      for (int i = 0; i < k; i++) offer(CMD_PAY, 8'($urandom), IGN_LOAD);
      offer(CMD_END, 8'h00, IGN_LOAD);
      send_until_ack(with_crc);
      k = 0;
      forever begin
         offer(CMD_SLOT, 8'h00, IGN_SEND);
         k++;
         if (k < 4 && $urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) offer(CMD_TMO, 8'h00, IGN_WAIT);
            else offer(CMD_RX, plain_reply(), IGN_WAIT);
         end else begin
            offer(CMD_RX, CH_ACK, IGN_WAIT);
            break;
         end
      end
      for (int i = 0; i < 5; i++) offer(CMD_RX, 8'($urandom), IGN_FLUSH);
      push_item(CMD_TMO, 8'h00);
      for (int i = 0; i < 8; i++) push_item(3'($urandom_range(0, 7)), 8'($urandom));
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
